/* hw/rtl/utp_pkg.sv */
`default_nettype none

package utp_pkg;

  localparam int unsigned OffsetBits = 32;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned CodeBits   = 21;
  localparam int unsigned PenBits    = 13;

  localparam logic [11:0] WrapWidthReset    = 12'd320;
  localparam logic [7:0]  LinesPerPageReset = 8'd16;

  localparam logic [CodeBits-1:0] CodeCr = CodeBits'(8'h0D);
  localparam logic [CodeBits-1:0] CodeLf = CodeBits'(8'h0A);

  typedef enum logic {
    ActText = 1'b0,
    ActEnd  = 1'b1
  } action_e;

  typedef enum logic {
    KindPage  = 1'b0,
    KindLines = 1'b1
  } kind_e;

  typedef enum logic {
    RegWrapWidth    = 1'b0,
    RegLinesPerPage = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [11:0] wrap_width;
    logic [7:0]  lines_per_page;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic                 kind;
    logic [ValueBits-1:0] value;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/utf8_text_paginator.sv */
// channel   direction  handshake               payload
// in        sink       in_valid_i/in_ready_o   action_i, data_byte_i, char_width_i
// out       source     out_valid_o/out_ready_i kind_o, value_o
// cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One input item per cycle; a result is registered into the output
// register, or into the skid while the output is held. Results sit
// in a two-entry output buffer (output register plus skid), so input
// stalls only when both are full. cfg_ready_o is always high. Reset
// clears all counters and the decoder and loads the register defaults.
`default_nettype none

module utf8_text_paginator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [7:0]  char_width_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [31:0]      value_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [11:0] cfg_data_i
);

  utp_pkg::cfg_t cfg_q;
  utp_pkg::res_t res;
  utp_pkg::res_t out_q, out_d;
  utp_pkg::res_t skid_q, skid_d;
  logic          accept;
  logic          pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wrap_width     <= utp_pkg::WrapWidthReset;
      cfg_q.lines_per_page <= utp_pkg::LinesPerPageReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        utp_pkg::RegWrapWidth:    cfg_q.wrap_width     <= cfg_data_i;
        utp_pkg::RegLinesPerPage: cfg_q.lines_per_page <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !skid_q.valid;
  assign accept     = in_valid_i && in_ready_o;

  utp_core u_core (
    .clk_i,
    .rst_ni,
    .accept_i     (accept),
    .action_i,
    .data_byte_i,
    .char_width_i,
    .cfg_i        (cfg_q),
    .res_o        (res)
  );

  assign pop = out_q.valid && out_ready_i;

  always_comb begin
    out_d  = out_q;
    skid_d = skid_q;
    if (out_q.valid && !pop) begin
      if (res.valid) skid_d = res;
    end else if (skid_q.valid) begin
      out_d  = skid_q;
      skid_d = res;
    end else begin
      out_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q  <= '0;
      skid_q <= '0;
    end else begin
      out_q  <= out_d;
      skid_q <= skid_d;
    end
  end

  assign out_valid_o = out_q.valid;
  assign kind_o      = out_q.kind;
  assign value_o     = out_q.value;

endmodule

`default_nettype wire

/* hw/rtl/utp_core.sv */
`default_nettype none

module utp_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic        action_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [7:0]  char_width_i,
  input  wire utp_pkg::cfg_t cfg_i,
  output utp_pkg::res_t    res_o
);

  logic [utp_pkg::CodeBits-1:0]   pcode_q, pcode_d;
  logic [1:0]                     need_q, need_d;
  logic [utp_pkg::OffsetBits-1:0] pos_q, pos_d;
  logic [utp_pkg::OffsetBits-1:0] cstart_q, cstart_d;
  logic [utp_pkg::PenBits-1:0]    pen_q, pen_d;
  logic [7:0]                     lpage_q, lpage_d;
  logic [utp_pkg::ValueBits-1:0]  ltotal_q, ltotal_d;

  logic                           done;
  logic [utp_pkg::CodeBits-1:0]   code;
  logic                           is_lf;
  logic [7:0]                     cw;
  logic [utp_pkg::PenBits:0]      pen_sum;
  logic                           wrap;
  logic [7:0]                     lpage_inc;
  logic [utp_pkg::ValueBits-1:0]  ltotal_inc;
  logic                           page;

  assign ltotal_inc = (&ltotal_q) ? ltotal_q : ltotal_q + 1'b1;

  always_comb begin
    pcode_d  = pcode_q;
    need_d   = need_q;
    pos_d    = pos_q;
    cstart_d = cstart_q;
    pen_d    = pen_q;
    lpage_d  = lpage_q;
    ltotal_d = ltotal_q;
    done     = 1'b0;
    code     = '0;
    is_lf    = 1'b0;
    cw       = '0;
    pen_sum  = '0;
    wrap     = 1'b0;
    lpage_inc = lpage_q + 8'd1;
    page     = 1'b0;
    res_o    = '0;

    if (accept_i) begin
      if (action_i == utp_pkg::ActEnd) begin
        res_o.valid = 1'b1;
        res_o.kind  = utp_pkg::KindLines;
        res_o.value = ltotal_inc;
        pcode_d  = '0;
        need_d   = '0;
        pos_d    = '0;
        cstart_d = '0;
        pen_d    = '0;
        lpage_d  = '0;
        ltotal_d = '0;
      end else begin
        if (need_q == 2'd0) cstart_d = pos_q;
        pos_d = (&pos_q) ? pos_q : pos_q + 1'b1;

        // continuation byte extends an open sequence; anything else restarts
        if (need_q != 2'd0 && data_byte_i[7:6] == 2'b10) begin
          pcode_d = {pcode_q[utp_pkg::CodeBits-7:0], data_byte_i[5:0]};
          need_d  = need_q - 2'd1;
          done    = (need_q == 2'd1);
          code    = pcode_d;
        end else begin
          need_d = 2'd0;
          priority if (!data_byte_i[7]) begin
            done = 1'b1;
            code = utp_pkg::CodeBits'(data_byte_i);
          end else if (data_byte_i[7:5] == 3'b110) begin
            pcode_d = utp_pkg::CodeBits'(data_byte_i[4:0]);
            need_d  = 2'd1;
          end else if (data_byte_i[7:4] == 4'b1110) begin
            pcode_d = utp_pkg::CodeBits'(data_byte_i[3:0]);
            need_d  = 2'd2;
          end else if (data_byte_i[7:3] == 5'b11110) begin
            pcode_d = utp_pkg::CodeBits'(data_byte_i[2:0]);
            need_d  = 2'd3;
          end else begin
            done = 1'b1;
            code = utp_pkg::CodeBits'(data_byte_i);
          end
        end

        if (done && code != utp_pkg::CodeCr) begin
          is_lf   = (code == utp_pkg::CodeLf);
          cw      = is_lf ? 8'd0 : char_width_i;
          pen_sum = {1'b0, pen_q} + (utp_pkg::PenBits+1)'(cw);
          wrap    = pen_sum >= (utp_pkg::PenBits+1)'(cfg_i.wrap_width);
          if (wrap || is_lf) begin
            lpage_d  = lpage_inc;
            ltotal_d = ltotal_inc;
            pen_d    = utp_pkg::PenBits'(cw);
            page     = (cfg_i.lines_per_page != 8'd0) && (lpage_inc == cfg_i.lines_per_page);
          end else begin
            pen_d = pen_sum[utp_pkg::PenBits-1:0];
          end
          if (page) begin
            lpage_d     = '0;
            res_o.valid = 1'b1;
            res_o.kind  = utp_pkg::KindPage;
            // a soft wrap starts the page at the wrapping character
            res_o.value = wrap ? utp_pkg::ValueBits'(cstart_d) : utp_pkg::ValueBits'(pos_d);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcode_q  <= '0;
      need_q   <= '0;
      pos_q    <= '0;
      cstart_q <= '0;
      pen_q    <= '0;
      lpage_q  <= '0;
      ltotal_q <= '0;
    end else begin
      pcode_q  <= pcode_d;
      need_q   <= need_d;
      pos_q    <= pos_d;
      cstart_q <= cstart_d;
      pen_q    <= pen_d;
      lpage_q  <= lpage_d;
      ltotal_q <= ltotal_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/utp_checker.sv */
`default_nettype none

module utp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        kind_o,
  input wire logic [31:0] value_o,
  input wire logic        cfg_ready_o
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(value_o))
    else $error("output item changed while stalled");

  // the input only backs up behind a pending result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // a line count is always at least one
  a_lines_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == utp_pkg::KindLines |-> value_o != 32'd0)
    else $error("line count of zero");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result present right after reset");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind utf8_text_paginator utp_checker u_utp_checker (.*);

`default_nettype wire

/* tb/utf8_text_paginator_test.sv */
`timescale 1ns / 100ps

module utf8_text_paginator_test;

  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned ItemsPerPhase = 300;

  // Tracks decoder, pen and line counters; queues the page offsets and
  // line totals that the block should produce.
  class pagination_tracker;
    typedef struct {
      logic        kind;
      logic [31:0] value;
    } break_rec_t;

    logic [11:0] wrap_px;
    logic [7:0]  page_len;
    logic [20:0] cp_acc;
    logic [1:0]  cont_left;
    logic [31:0] byte_pos;
    logic [31:0] seq_head;
    logic [12:0] pen;
    logic [7:0]  page_lines;
    logic [31:0] line_count;
    break_rec_t  pending_breaks[$];

    function new();
      wrap_px  = utp_pkg::WrapWidthReset;
      page_len = utp_pkg::LinesPerPageReset;
      clear_text();
    endfunction

    function void clear_text();
      cp_acc     = '0;
      cont_left  = '0;
      byte_pos   = '0;
      seq_head   = '0;
      pen        = '0;
      page_lines = '0;
      line_count = '0;
    endfunction

    function void write_reg(utp_pkg::reg_idx_e idx, logic [11:0] data);
      if (idx == utp_pkg::RegWrapWidth) begin
        wrap_px = data;
      end else begin
        page_len = data[7:0];
      end
    endfunction

    function int pending();
      return pending_breaks.size();
    endfunction

    // returns 1 once a code point is complete
    function bit decode(logic [7:0] b, output logic [20:0] code);
      code = '0;
      if (cont_left != 0) begin
        if (b[7:6] == 2'b10) begin
          cp_acc    = {cp_acc[14:0], b[5:0]};
          cont_left = cont_left - 2'd1;
          code      = cp_acc;
          return cont_left == 0;
        end
        // broken sequence: drop it, b starts over as a lead byte
        cont_left = '0;
      end
      if (b[7] == 1'b0) begin
        code = {13'd0, b};
        return 1'b1;
      end
      if (b[7:5] == 3'b110) begin
        cp_acc    = {16'd0, b[4:0]};
        cont_left = 2'd1;
        return 1'b0;
      end
      if (b[7:4] == 4'b1110) begin
        cp_acc    = {17'd0, b[3:0]};
        cont_left = 2'd2;
        return 1'b0;
      end
      if (b[7:3] == 5'b11110) begin
        cp_acc    = {18'd0, b[2:0]};
        cont_left = 2'd3;
        return 1'b0;
      end
      // invalid lead byte stands for itself
      code = {13'd0, b};
      return 1'b1;
    endfunction

    function bit break_line();
      page_lines = page_lines + 8'd1;
      if (line_count != '1) line_count = line_count + 32'd1;
      pen = '0;
      return page_len != 0 && page_lines == page_len;
    endfunction

    function void note_item(utp_pkg::action_e act, logic [7:0] b, logic [7:0] w);
      logic [20:0] code;
      logic [7:0]  adv;
      logic [13:0] reach;
      bit          new_page;
      logic [31:0] start;
      break_rec_t  rec;
      new_page = 1'b0;
      start    = '0;
      if (act == utp_pkg::ActEnd) begin
        rec.kind  = utp_pkg::KindLines;
        rec.value = (line_count == '1) ? line_count : line_count + 32'd1;
        pending_breaks.push_back(rec);
        clear_text();
        return;
      end
      if (cont_left == 0) seq_head = byte_pos;
      if (byte_pos != '1) byte_pos = byte_pos + 32'd1;
      if (!decode(b, code)) return;
      if (code == utp_pkg::CodeCr) return;
      adv   = (code == utp_pkg::CodeLf) ? 8'd0 : w;
      reach = {1'b0, pen} + {6'd0, adv};
      if (reach >= {2'b00, wrap_px}) begin
        if (break_line()) begin
          new_page = 1'b1;
          start    = seq_head;
        end
      end else if (code == utp_pkg::CodeLf) begin
        if (break_line()) begin
          new_page = 1'b1;
          start    = byte_pos;
        end
      end
      pen = pen + {5'd0, adv};
      if (new_page) begin
        page_lines = '0;
        rec.kind   = utp_pkg::KindPage;
        rec.value  = start;
        pending_breaks.push_back(rec);
      end
    endfunction

    // empty string when the result matches the oldest expectation
    function string check_result(logic got_kind, logic [31:0] got_value);
      break_rec_t rec;
      string      why;
      why = "";
      if (pending_breaks.size() == 0) begin
        return $sformatf("unexpected result kind %0d value %0d", got_kind, got_value);
      end
      rec = pending_breaks.pop_front();
      if (got_kind !== rec.kind) begin
        why = $sformatf("kind %0d, expected %0d; ", got_kind, rec.kind);
      end
      if (got_value !== rec.value) begin
        why = {why, $sformatf("value %0d, expected %0d", got_value, rec.value)};
      end
      return why;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        action_i;
  logic [7:0]  data_byte_i;
  logic [7:0]  char_width_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        kind_o;
  logic [31:0] value_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [11:0] cfg_data_i;

  pagination_tracker tracker;
  int unsigned       mismatches;
  int unsigned       items_sent;
  int unsigned       burst_left;
  int unsigned       idle_cycles;

  utf8_text_paginator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .data_byte_i  (data_byte_i),
    .char_width_i (char_width_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string why);
    mismatches++;
    if (mismatches <= 50) $display("%0t: mismatch: %s", $time, why);
  endtask

  // Sampling right after the edge sees the values that were present at it.
  always @(posedge clk_i) begin : watch_ports
    string why;
    if (out_valid_o && out_ready_i) begin
      why = tracker.check_result(kind_o, value_o);
      if (why != "") report_mismatch(why);
    end
    if (cfg_valid_i && cfg_ready_o) begin
      tracker.write_reg(utp_pkg::reg_idx_e'(cfg_index_i), cfg_data_i);
    end
    if (in_valid_i && in_ready_o) begin
      tracker.note_item(utp_pkg::action_e'(action_i), data_byte_i, char_width_i);
    end
    if ((out_valid_o && out_ready_i) || (cfg_valid_i && cfg_ready_o) ||
        (in_valid_i && in_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("utf8_text_paginator test failed");
      $finish;
    end
  end

  // Result side: quiet stretches, random and periodic stalls, and now and
  // then a long hold so the output buffer fills and the input stalls.
  initial begin : receiver
    int unsigned tick;
    int unsigned taken;
    int unsigned hold_left;
    int unsigned next_hold;
    tick      = 0;
    taken     = 0;
    hold_left = 0;
    next_hold = 20;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) taken++;
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (taken >= next_hold) begin
        hold_left = HoldCycles;
        next_hold = taken + 300;
        out_ready_i <= 1'b0;
      end else begin
        case ((tick >> 8) % 4)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= ((tick % 7) < 4);
          default: out_ready_i <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  // Called at a clock edge; returns at the edge that accepted the item, or after a random idle gap that follows it.
  task automatic put_item(input utp_pkg::action_e act, input logic [7:0] b,
                          input logic [7:0] w);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    action_i     <= act;
    data_byte_i  <= b;
    char_width_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic put_text(input logic [7:0] b, input logic [7:0] w);
    put_item(utp_pkg::ActText, b, w);
  endtask

  task automatic set_config(input logic [11:0] wrap, input logic [11:0] lpp_word);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= utp_pkg::RegWrapWidth;
    cfg_data_i  <= wrap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= utp_pkg::RegLinesPerPage;
    cfg_data_i  <= lpp_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // first edge lets the last accepted item reach the tracker
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_width();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return 8'($urandom_range(0, 40));
    if (r < 9) return 8'($urandom_range(0, 255));
    return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
  endfunction

  // One character as a byte sequence; widths on bytes that complete
  // nothing are random since the block ignores them.
  task automatic send_random_char(input int unsigned end_one_in);
    int unsigned pick;
    int unsigned seq_len;
    int unsigned k;
    logic [7:0]  w;
    logic [7:0]  b;
    logic [20:0] cp;
    pick = $urandom_range(0, 99);
    w    = pick_width();
    cp   = 21'($urandom);
    if (end_one_in != 0 && $urandom_range(1, end_one_in) == 1) begin
      put_item(utp_pkg::ActEnd, 8'($urandom), 8'($urandom));
    end else if (pick < 40) begin
      put_text(8'($urandom_range(8'h20, 8'h7E)), w);
    end else if (pick < 48) begin
      put_text(8'h0A, w);
    end else if (pick < 52) begin
      put_text(8'h0D, w);
    end else if (pick < 56) begin
      put_text(8'h0D, 8'($urandom));
      put_text(8'h0A, w);
    end else if (pick < 68) begin
      put_text({3'b110, cp[10:6]}, 8'($urandom));
      put_text({2'b10, cp[5:0]}, w);
    end else if (pick < 76) begin
      put_text({4'b1110, cp[15:12]}, 8'($urandom));
      put_text({2'b10, cp[11:6]}, 8'($urandom));
      put_text({2'b10, cp[5:0]}, w);
    end else if (pick < 82) begin
      put_text({5'b11110, cp[20:18]}, 8'($urandom));
      put_text({2'b10, cp[17:12]}, 8'($urandom));
      put_text({2'b10, cp[11:6]}, 8'($urandom));
      put_text({2'b10, cp[5:0]}, w);
    end else if (pick < 86) begin
      b = ($urandom_range(0, 1) != 0) ? {2'b10, cp[5:0]} : {5'b11111, cp[2:0]};
      put_text(b, w);
    end else if (pick < 92) begin
      // sequence cut short by a byte that is not a continuation
      seq_len = $urandom_range(2, 4);
      case (seq_len)
        2: put_text({3'b110, cp[4:0]}, 8'($urandom));
        3: put_text({4'b1110, cp[3:0]}, 8'($urandom));
        default: put_text({5'b11110, cp[2:0]}, 8'($urandom));
      endcase
      k = $urandom_range(0, seq_len - 2);
      repeat (k) put_text({2'b10, 6'($urandom)}, 8'($urandom));
      b = 8'($urandom);
      if (b[7:6] == 2'b10) b[6] = 1'b1;
      put_text(b, w);
    end else if (pick < 95) begin
      // overlong encodings of newline and carriage return
      b = ($urandom_range(0, 1) != 0) ? 8'h8A : 8'h8D;
      if ($urandom_range(0, 1) != 0) begin
        put_text(8'hC0, 8'($urandom));
      end else begin
        put_text(8'hE0, 8'($urandom));
        put_text(8'h80, 8'($urandom));
      end
      put_text(b, w);
    end else begin
      put_text(8'($urandom), w);
    end
  endtask

  task automatic run_phase(input logic [11:0] wrap, input logic [11:0] lpp_word,
                           input int unsigned end_one_in);
    int unsigned target;
    wait_drain();
    set_config(wrap, lpp_word);
    target = items_sent + ItemsPerPhase;
    while (items_sent < target) send_random_char(end_one_in);
    put_item(utp_pkg::ActEnd, 8'($urandom), 8'($urandom));
  endtask

  initial begin
    tracker      = new();
    mismatches   = 0;
    items_sent   = 0;
    burst_left   = 0;
    idle_cycles  = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = utp_pkg::ActText;
    data_byte_i  = '0;
    char_width_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = utp_pkg::RegWrapWidth;
    cfg_data_i   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: two lines per page, narrow wrap
    set_config(12'd100, 12'd2);
    put_text(8'h00, 8'd0);
    put_text(8'h41, 8'd255);   // wide char wraps by itself
    put_text(8'h0D, 8'd7);     // carriage return is dropped
    put_text(8'h0A, 8'd9);     // newline fills the page
    put_text(8'hC3, 8'd3);
    put_text(8'hA9, 8'd30);
    put_text(8'hE2, 8'd0);
    put_text(8'h82, 8'd0);
    put_text(8'hAC, 8'd40);
    put_text(8'hF0, 8'd1);
    put_text(8'h9F, 8'd2);
    put_text(8'h98, 8'd3);
    put_text(8'h80, 8'd50);    // soft wrap
    put_text(8'h80, 8'd20);    // stray continuation
    put_text(8'hFF, 8'd255);   // invalid lead, wraps and fills the page
    put_text(8'hE2, 8'd5);
    put_text(8'h41, 8'd10);    // breaks the open sequence
    put_text(8'hC0, 8'd0);
    put_text(8'h8A, 8'd77);    // overlong newline
    put_text(8'hF8, 8'd5);
    put_text(8'hF4, 8'd0);     // left open by the end item
    put_item(utp_pkg::ActEnd, 8'hFF, 8'hFF);
    put_text(8'h0A, 8'd0);
    put_item(utp_pkg::ActEnd, 8'h00, 8'h00);

    run_phase(12'd320, 12'd16, 60);
    run_phase(12'd1, 12'd1, 80);
    run_phase(12'hFFF, 12'hFFF, 60);
    run_phase(12'h000, 12'h000, 0);
    run_phase(12'($urandom_range(1, 600)), 12'($urandom_range(1, 6)), 50);
    run_phase(12'd200, 12'hF03, 40);
    wait_drain();

    if (mismatches == 0) begin
      $display("utf8_text_paginator test passed");
    end else begin
      $display("utf8_text_paginator test failed");
    end
    $finish;
  end

endmodule
